// ----- sv/shell_style_arg_tokenizer_top_assert.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef SHELL_STYLE_ARG_TOKENIZER_TOP_ASSERT_SVH
`define SHELL_STYLE_ARG_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication.
`define SST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

// ----- sv/sst_pkg.sv -----
`timescale 1ns / 1ps
package sst_pkg;

   localparam int CHAR_W   = 8;
   localparam int STATE_W  = 3;
   localparam int STATUS_W = 2;
   localparam int ERR_W    = 3;

   localparam logic [STATE_W-1:0] ST_START    = 3'd0;
   localparam logic [STATE_W-1:0] ST_INSIDE   = 3'd1;
   localparam logic [STATE_W-1:0] ST_SINGLEQ  = 3'd2;
   localparam logic [STATE_W-1:0] ST_DOUBLEQ  = 3'd3;
   localparam logic [STATE_W-1:0] ST_ESC_WORD = 3'd4;
   localparam logic [STATE_W-1:0] ST_ESC_DQ   = 3'd5;
   localparam logic [STATE_W-1:0] ST_COMMENT  = 3'd6;
   localparam logic [STATE_W-1:0] ST_ESC_BEG  = 3'd7;

   localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

   localparam logic [STATUS_W-1:0] STAT_WORK  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_ERROR = 2'd3;

   localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_OPEN_SQ  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_OPEN_DQ  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_ESC_WORD = 3'd3;
   localparam logic [ERR_W-1:0] ERR_ESC_DQ   = 3'd4;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              at_end;
   } req_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   out_char;
      logic                append;
      logic [STATUS_W-1:0] status;
      logic [ERR_W-1:0]    error_kind;
   } rsp_item_type;

   // Handoff from the input register to the lexer.
   typedef struct packed {
      logic         advance;
      req_item_type item;
   } stage_type;

   function automatic logic is_ws(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

// ----- sv/sst_req_if.sv -----
`timescale 1ns / 1ps
interface sst_req_if import sst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ch;
   logic              at_end;

   modport source(output valid, ch, at_end, input ready);
   modport sink(input valid, ch, at_end, output ready);
endinterface

// ----- sv/sst_rsp_if.sv -----
`timescale 1ns / 1ps
interface sst_rsp_if import sst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   out_char;
   logic                append;
   logic [STATUS_W-1:0] status;
   logic [ERR_W-1:0]    error_kind;

   modport source(output valid, out_char, append, status, error_kind, input ready);
   modport sink(input valid, out_char, append, status, error_kind, output ready);
endinterface

// ----- sv/sst_in_reg.sv -----
`timescale 1ns / 1ps
module sst_in_reg import sst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sst_req_if.sink   req_if,
   input  logic      take,
   output stage_type stage
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;
   logic         advance;
   logic         load;

   assign advance      = valid_ff && take;
   assign req_if.ready = !valid_ff || take;
   assign load         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in       = 1'b1;
         item_in.ch     = req_if.ch;
         item_in.at_end = req_if.at_end;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage.advance = advance;
   assign stage.item    = item_ff;

endmodule

// ----- sv/sst_lexer.sv -----
`timescale 1ns / 1ps
`include "shell_style_arg_tokenizer_top_assert.svh"
module sst_lexer import sst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  stage_type    stage,
   output rsp_item_type result
);

   logic [STATE_W-1:0] state_ff;
   logic [STATE_W-1:0] state_in;
   logic [STATE_W-1:0] nst;
   logic [CHAR_W-1:0]  c;
   logic               app;
   logic [STATUS_W-1:0] status;
   logic [ERR_W-1:0]   err;

   always_comb begin
      c      = stage.item.ch;
      app    = 1'b0;
      status = STAT_WORK;
      err    = ERR_NONE;
      nst    = state_ff;
      if (stage.item.at_end) begin
         nst = ST_START;
         case (state_ff)
            ST_INSIDE:   status = STAT_DONE;
            ST_SINGLEQ: begin
               status = STAT_ERROR;
               err    = ERR_OPEN_SQ;
            end
            ST_DOUBLEQ: begin
               status = STAT_ERROR;
               err    = ERR_OPEN_DQ;
            end
            ST_ESC_WORD, ST_ESC_BEG: begin
               status = STAT_ERROR;
               err    = ERR_ESC_WORD;
            end
            ST_ESC_DQ: begin
               status = STAT_ERROR;
               err    = ERR_ESC_DQ;
            end
            default:     status = STAT_EMPTY;
         endcase
      end else begin
         case (state_ff)
            ST_INSIDE: begin
               if (is_ws(c)) begin
                  status = STAT_DONE;
                  nst    = ST_START;
               end else if (c == CH_SQUOTE) begin
                  nst = ST_SINGLEQ;
               end else if (c == CH_DQUOTE) begin
                  nst = ST_DOUBLEQ;
               end else if (c == CH_BSLASH) begin
                  nst = ST_ESC_WORD;
               end else begin
                  app = 1'b1;
               end
            end
            ST_SINGLEQ: begin
               if (c == CH_SQUOTE) begin
                  nst = ST_INSIDE;
               end else begin
                  app = 1'b1;
               end
            end
            ST_DOUBLEQ: begin
               if (c == CH_DQUOTE) begin
                  nst = ST_INSIDE;
               end else if (c == CH_BSLASH) begin
                  nst = ST_ESC_DQ;
               end else begin
                  app = 1'b1;
               end
            end
            ST_ESC_WORD: begin
               app = (c != CH_NL);
               nst = ST_INSIDE;
            end
            ST_ESC_DQ: begin
               app = (c != CH_NL);
               nst = ST_DOUBLEQ;
            end
            ST_ESC_BEG: begin
               if (c == CH_NL) begin
                  nst = ST_START;
               end else begin
                  app = 1'b1;
                  nst = ST_INSIDE;
               end
            end
            ST_COMMENT: begin
               if (c == CH_NL) begin
                  nst = ST_START;
               end
            end
            default: begin
               if (is_ws(c)) begin
                  nst = ST_START;
               end else if (c == CH_SQUOTE) begin
                  nst = ST_SINGLEQ;
               end else if (c == CH_DQUOTE) begin
                  nst = ST_DOUBLEQ;
               end else if (c == CH_BSLASH) begin
                  nst = ST_ESC_BEG;
               end else if (c == CH_HASH) begin
                  nst = ST_COMMENT;
               end else begin
                  app = 1'b1;
                  nst = ST_INSIDE;
               end
            end
         endcase
      end
   end

   assign state_in          = stage.advance ? nst : state_ff;
   assign result.out_char   = app ? c : CH_NUL;
   assign result.append     = app;
   assign result.status     = status;
   assign result.error_kind = err;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   `SST_ASSERT_NXT(a_end_restarts, clock, reset, stage.advance && stage.item.at_end, state_ff == ST_START)
   `SST_ASSERT_NXT(a_hold_state, clock, reset, !stage.advance, state_ff == $past(state_ff))
   `SST_ASSERT_IMP(a_err_in_quote, clock, reset, stage.item.at_end && ((state_ff == ST_SINGLEQ) || (state_ff == ST_DOUBLEQ)), result.status == STAT_ERROR)

endmodule

// ----- sv/sst_out_reg.sv -----
`timescale 1ns / 1ps
module sst_out_reg import sst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  rsp_item_type result,
   sst_rsp_if.source    rsp_if,
   output logic         take
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;
   rsp_item_type data_in;

   assign take     = !valid_ff || rsp_if.ready;
   assign valid_in = take ? advance : valid_ff;
   assign data_in  = (take && advance) ? result : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.out_char   = data_ff.out_char;
   assign rsp_if.append     = data_ff.append;
   assign rsp_if.status     = data_ff.status;
   assign rsp_if.error_kind = data_ff.error_kind;

endmodule

// ----- sv/shell_style_arg_tokenizer_top.sv -----
`timescale 1ns / 1ps
// Shell-style argument tokenizer: one character (or end-of-input mark) per req
// transfer, exactly one rsp transfer per req transfer, in order. Throughput is
// one item per clock while neither side stalls. A result is offered on rsp after
// it has passed the input register, which loads on the req transfer, and the
// result register, which loads when the output side takes it from the lexer. The
// rate is set by the 3-bit lexer state register, which steps once per item as the
// item moves into the result register. Either side may stall at any time; ready
// on req depends combinationally on ready on rsp.
`include "shell_style_arg_tokenizer_top_assert.svh"
module shell_style_arg_tokenizer_top import sst_pkg::*; (
   input logic       clock,
   input logic       reset,
   sst_req_if.sink   req_if,
   sst_rsp_if.source rsp_if
);

   stage_type    stage;
   rsp_item_type result;
   logic         take;

   sst_in_reg u_in_reg (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .take   (take),
      .stage  (stage)
   );

   sst_lexer u_lexer (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .result (result)
   );

   sst_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .advance (stage.advance),
      .result  (result),
      .rsp_if  (rsp_if),
      .take    (take)
   );

   `SST_ASSERT_IMP(a_append_working, clock, reset, rsp_if.valid && rsp_if.append, rsp_if.status == STAT_WORK)
   `SST_ASSERT_IMP(a_err_kind_only_on_err, clock, reset, rsp_if.valid && (rsp_if.status != STAT_ERROR), rsp_if.error_kind == ERR_NONE)
   `SST_ASSERT_IMP(a_char_zero_no_append, clock, reset, rsp_if.valid && !rsp_if.append, rsp_if.out_char == CH_NUL)

endmodule
